// File: rtl/core/bads_pkg.sv
// types, constants and codes shared by the box-average downscaler
// no dependencies; the top level, checker and bench refer to it by scoped names
`timescale 1ns / 1ps

package bads_pkg;

    // configuration port
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int DIM_CFG_W   = 13;
    localparam int NUM_CFG_W   = 13;
    localparam int DEN_W       = 9;
    localparam int DEN_MAX     = 511;

    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_NUM  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_DEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BPP_MODE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREMULT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_RB    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT      = 3'd7;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_pix_t;

    typedef struct packed {
        logic [15:0] pixel565;
        logic        row_end;
        logic        image_end;
    } out_pix_t;

    typedef enum logic [2:0] {
        ST_CFG,
        ST_IDLE,
        ST_READ,
        ST_OP,
        ST_WAIT,
        ST_MUL,
        ST_PACK,
        ST_COMMIT
    } state_t;

    // divider jobs, lowest code served first
    localparam int OP_COUNT = 7;
    typedef enum logic [2:0] {
        OP_E1,
        OP_COL,
        OP_ROW,
        OP_RED,
        OP_GREEN,
        OP_BLUE,
        OP_ALPHA
    } op_t;

endpackage

// File: rtl/core/bads_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bads_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/bads_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// no dependencies; done pulses one cycle with the quotient valid
`timescale 1ns / 1ps

module bads_div #(
    parameter int DVD_W = 27,
    parameter int DVS_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           fits;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/box_average_downscale_rgb565.sv
// top level of the box-average downscaler: sequencer, counters and datapath
// depends on bads_pkg, bads_ram (column sum store) and bads_div (shared divider)
`timescale 1ns / 1ps

// Source pixels come in raster order on the src channel; each non-overlapping
// block with edges at floor(k*num/den) on both axes is averaged and sent as
// one RGB565 pixel on the dst channel, with row_end and image_end flags.
// Trailing partial columns and rows produce nothing. Every divide goes
// through one shared radix-2 divider (E_W, its dividend width, is
// 27 with the default parameters). A pixel that closes a column block adds
// one divide; a pixel that completes a block runs six divides plus packing.
// src_ready is low while a pixel is worked on. A result waiting
// on dst does not block the next pixel unless a second result is due. After
// reset or a configuration write the block computes the first block edge
// before it takes pixels; a write restarts the frame.
module box_average_downscale_rgb565 #(
    parameter int MAX_OUT_WIDTH = 256,
    parameter int MAX_SRC_DIM   = 4096,
    parameter int MAX_BLOCK     = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               src_valid,
    output logic                               src_ready,
    input  bads_pkg::in_pix_t                  src_pixel,
    output logic                               dst_valid,
    input  logic                               dst_ready,
    output bads_pkg::out_pix_t                 dst_pixel,
    input  logic                               cfg_write,
    input  logic [bads_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bads_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // widths that follow from the parameters
    localparam int DIM_W  = $clog2(MAX_SRC_DIM + 1);
    localparam int OCNT_W = $clog2(MAX_OUT_WIDTH + 1);
    localparam int COL_W  = $clog2(MAX_OUT_WIDTH);
    localparam int KMAX   = (MAX_SRC_DIM > MAX_OUT_WIDTH ? MAX_SRC_DIM : MAX_OUT_WIDTH) + 2;
    localparam int K_W    = $clog2(KMAX + 1);
    localparam int N_W    = $clog2(bads_pkg::DEN_MAX * MAX_BLOCK + 1);
    localparam int E_W    = K_W + N_W;
    localparam int BLK_W  = $clog2(MAX_BLOCK + 1);
    localparam int AREA_W = 2 * BLK_W;
    localparam int SUM_W  = $clog2(255 * MAX_BLOCK * MAX_BLOCK + 1);
    localparam int DVS_W  = bads_pkg::DEN_W > AREA_W ? bads_pkg::DEN_W : AREA_W;
    localparam int WC_W   = (DIM_W > bads_pkg::DIM_CFG_W ? DIM_W : bads_pkg::DIM_CFG_W) + 1;
    localparam int NC_W   = (N_W > bads_pkg::NUM_CFG_W ? N_W : bads_pkg::NUM_CFG_W) + 1;
    localparam int OP_W   = $bits(bads_pkg::op_t);
    localparam int OP_COUNT_W = bads_pkg::OP_COUNT;

    // configuration registers
    logic [bads_pkg::DIM_CFG_W-1:0] width_reg;
    logic [bads_pkg::DIM_CFG_W-1:0] height_reg;
    logic [bads_pkg::NUM_CFG_W-1:0] num_reg;
    logic [bads_pkg::DEN_W-1:0]     den_reg;
    logic                           bpp_reg;
    logic                           premult_reg;
    logic                           swap_reg;
    logic                           cfg_hit;

    // sequencer
    bads_pkg::state_t state_reg;
    bads_pkg::state_t state_next;
    logic [OP_COUNT_W-1:0] pending_reg;
    bads_pkg::op_t    op_reg;
    bads_pkg::op_t    op_pick;
    logic             op_any;
    logic             init_reg;

    // frame position
    logic [DIM_W-1:0]  src_col_reg;
    logic [DIM_W-1:0]  src_row_reg;
    logic [OCNT_W-1:0] out_col_reg;
    logic [DIM_W-1:0]  out_row_reg;
    logic [E_W-1:0]    col_edge_reg;
    logic [E_W-1:0]    col_start_reg;
    logic [E_W-1:0]    row_edge_reg;
    logic [E_W-1:0]    row_start_reg;
    logic [E_W-1:0]    col_next_reg;
    logic [E_W-1:0]    row_next_reg;
    logic [E_W-1:0]    e1_reg;
    logic [N_W-1:0]    n_eff_reg;
    logic [bads_pkg::DEN_W-1:0] d_eff_reg;

    // per-pixel datapath
    bads_pkg::in_pix_t pix_reg;
    logic [SUM_W-1:0]  sum_r_reg, sum_g_reg, sum_b_reg, sum_a_reg;
    logic [AREA_W-1:0] area_reg;
    logic [7:0]        avg_r_reg, avg_g_reg, avg_b_reg, avg_a_reg;
    logic [7:0]        col_r_reg, col_g_reg, col_b_reg;
    bads_pkg::out_pix_t dst_reg;
    logic              dst_valid_reg;

    // effective sizes and ratio
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [bads_pkg::DEN_W-1:0] d_calc;
    logic [N_W-1:0]   n_max, n_calc;

    // position decodes
    logic in_range, col_done, band_first, band_last, row_last, frame_last, emit;

    // store
    logic [4*SUM_W-1:0] ram_rdata, ram_wdata;
    logic               ram_we;
    logic [SUM_W-1:0]   rd_r, rd_g, rd_b, rd_a;
    logic [SUM_W-1:0]   new_r, new_g, new_b, new_a;

    // divider
    logic             div_start, div_done;
    logic [E_W-1:0]   div_dvd, div_q;
    logic [DVS_W-1:0] div_dvs;
    logic [K_W-1:0]   mul_k;
    logic [7:0]       q_byte;

    // packing
    logic [BLK_W-1:0]  blk_w, blk_h;
    logic [AREA_W-1:0] area_calc;
    logic [15:0]       prod_r, prod_g, prod_b;
    logic [7:0]        hi_c, lo_c;
    logic              rend, iend;
    logic              dst_free;

    // ---------------- configuration ----------------
    assign cfg_hit = cfg_write && (cfg_index < bads_pkg::CFG_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= bads_pkg::DIM_CFG_W'(128);
            height_reg  <= bads_pkg::DIM_CFG_W'(160);
            num_reg     <= bads_pkg::NUM_CFG_W'(1);
            den_reg     <= bads_pkg::DEN_W'(1);
            bpp_reg     <= 1'b0;
            premult_reg <= 1'b0;
            swap_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bads_pkg::CFG_SRC_WIDTH:  width_reg   <= cfg_data[bads_pkg::DIM_CFG_W-1:0];
                bads_pkg::CFG_SRC_HEIGHT: height_reg  <= cfg_data[bads_pkg::DIM_CFG_W-1:0];
                bads_pkg::CFG_SCALE_NUM:  num_reg     <= cfg_data[bads_pkg::NUM_CFG_W-1:0];
                bads_pkg::CFG_SCALE_DEN:  den_reg     <= cfg_data[bads_pkg::DEN_W-1:0];
                bads_pkg::CFG_BPP_MODE:   bpp_reg     <= cfg_data[0];
                bads_pkg::CFG_PREMULT:    premult_reg <= cfg_data[0];
                bads_pkg::CFG_SWAP_RB:    swap_reg    <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // zero size taken as one, oversize clamped to the largest source
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (WC_W'(width_reg) > WC_W'(MAX_SRC_DIM))
            w_eff = DIM_W'(MAX_SRC_DIM);
        else
            w_eff = DIM_W'(width_reg);
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (WC_W'(height_reg) > WC_W'(MAX_SRC_DIM))
            h_eff = DIM_W'(MAX_SRC_DIM);
        else
            h_eff = DIM_W'(height_reg);
    end

    // ratio clamped between one and MAX_BLOCK
    always_comb
    begin
        d_calc = (den_reg == '0) ? bads_pkg::DEN_W'(1) : den_reg;
        n_max  = N_W'(d_calc) * N_W'(MAX_BLOCK);
        if (NC_W'(num_reg) < NC_W'(d_calc))
            n_calc = N_W'(d_calc);
        else if (NC_W'(num_reg) > NC_W'(n_max))
            n_calc = n_max;
        else
            n_calc = N_W'(num_reg);
    end

    // ---------------- position decodes ----------------
    assign in_range   = out_col_reg < OCNT_W'(MAX_OUT_WIDTH);
    assign col_done   = (E_W'(src_col_reg) + E_W'(1)) == col_edge_reg;
    assign band_first = E_W'(src_row_reg) == row_start_reg;
    assign band_last  = (E_W'(src_row_reg) + E_W'(1)) == row_edge_reg;
    assign row_last   = ((DIM_W+1)'(src_col_reg) + 1'b1) >= (DIM_W+1)'(w_eff);
    assign frame_last = ((DIM_W+1)'(src_row_reg) + 1'b1) >= (DIM_W+1)'(h_eff);
    assign emit       = in_range && col_done && band_last;

    // ---------------- column sum store ----------------
    assign {rd_a, rd_r, rd_g, rd_b} = ram_rdata;
    assign new_r = band_first ? SUM_W'(pix_reg.red)   : rd_r + SUM_W'(pix_reg.red);
    assign new_g = band_first ? SUM_W'(pix_reg.green) : rd_g + SUM_W'(pix_reg.green);
    assign new_b = band_first ? SUM_W'(pix_reg.blue)  : rd_b + SUM_W'(pix_reg.blue);
    assign new_a = band_first ? SUM_W'(pix_reg.alpha) : rd_a + SUM_W'(pix_reg.alpha);
    assign ram_wdata = {new_a, new_r, new_g, new_b};

    bads_ram #(
        .WIDTH (4 * SUM_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (out_col_reg[COL_W-1:0]),
        .wdata (ram_wdata),
        .raddr (out_col_reg[COL_W-1:0]),
        .rdata (ram_rdata)
    );

    // block area, both sides at most MAX_BLOCK
    assign blk_w     = BLK_W'(col_edge_reg - col_start_reg);
    assign blk_h     = BLK_W'(row_edge_reg - row_start_reg);
    assign area_calc = AREA_W'(blk_w) * AREA_W'(blk_h);

    // ---------------- shared divider ----------------
    // lowest pending job first
    always_comb
    begin
        op_pick = bads_pkg::OP_E1;
        op_any  = 1'b0;
        for (int i = bads_pkg::OP_COUNT - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                op_pick = bads_pkg::op_t'(OP_W'(i));
                op_any  = 1'b1;
            end
        end
    end

    // edge jobs: k*num / den; average jobs: sum / area
    always_comb
    begin
        mul_k   = K_W'(1);
        div_dvd = '0;
        div_dvs = DVS_W'(d_eff_reg);
        case (op_pick)
            bads_pkg::OP_COL: mul_k = K_W'(out_col_reg) + K_W'(2);
            bads_pkg::OP_ROW: mul_k = K_W'(out_row_reg) + K_W'(2);
            default:          mul_k = K_W'(1);
        endcase
        case (op_pick)
            bads_pkg::OP_RED:
            begin
                div_dvd = E_W'(sum_r_reg);
                div_dvs = DVS_W'(area_reg);
            end
            bads_pkg::OP_GREEN:
            begin
                div_dvd = E_W'(sum_g_reg);
                div_dvs = DVS_W'(area_reg);
            end
            bads_pkg::OP_BLUE:
            begin
                div_dvd = E_W'(sum_b_reg);
                div_dvs = DVS_W'(area_reg);
            end
            bads_pkg::OP_ALPHA:
            begin
                div_dvd = E_W'(sum_a_reg);
                div_dvs = DVS_W'(area_reg);
            end
            default:
            begin
                div_dvd = E_W'(mul_k) * E_W'(n_eff_reg);
                div_dvs = DVS_W'(d_eff_reg);
            end
        endcase
    end

    bads_div #(
        .DVD_W (E_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // averages saturate at one byte
    assign q_byte = (div_q > E_W'(255)) ? 8'hFF : div_q[7:0];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bads_pkg::ST_CFG:    state_next = bads_pkg::ST_OP;
            bads_pkg::ST_IDLE:
                if (src_valid)
                    state_next = bads_pkg::ST_READ;
            bads_pkg::ST_READ:   state_next = bads_pkg::ST_OP;
            bads_pkg::ST_OP:
                if (op_any)
                    state_next = bads_pkg::ST_WAIT;
                else if (init_reg)
                    state_next = bads_pkg::ST_IDLE;
                else if (emit)
                    state_next = bads_pkg::ST_MUL;
                else
                    state_next = bads_pkg::ST_COMMIT;
            bads_pkg::ST_WAIT:
                if (div_done)
                    state_next = bads_pkg::ST_OP;
            bads_pkg::ST_MUL:    state_next = bads_pkg::ST_PACK;
            bads_pkg::ST_PACK:
                if (dst_free)
                    state_next = bads_pkg::ST_COMMIT;
            bads_pkg::ST_COMMIT: state_next = bads_pkg::ST_IDLE;
            default:             state_next = bads_pkg::ST_CFG;
        endcase
        // a register write restarts everything
        if (cfg_hit)
            state_next = bads_pkg::ST_CFG;
    end

    always_comb
    begin
        src_ready = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        unique case (state_reg)
            bads_pkg::ST_IDLE: src_ready = 1'b1;
            bads_pkg::ST_READ: ram_we    = in_range;
            bads_pkg::ST_OP:   div_start = op_any;
            default:           ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bads_pkg::ST_CFG;
        else
            state_reg <= state_next;
    end

    // ---------------- output register ----------------
    assign dst_free = !dst_valid_reg || dst_ready;

    assign prod_r = 16'(avg_r_reg) * 16'(avg_a_reg);
    assign hi_c   = swap_reg ? col_b_reg : col_r_reg;
    assign lo_c   = swap_reg ? col_r_reg : col_b_reg;
    assign rend   = (((OCNT_W+1)'(out_col_reg) + 1'b1) >= (OCNT_W+1)'(MAX_OUT_WIDTH))
                 || (col_next_reg > E_W'(w_eff));
    assign iend   = rend && (row_next_reg > E_W'(h_eff));
    assign prod_g = 16'(avg_g_reg) * 16'(avg_a_reg);
    assign prod_b = 16'(avg_b_reg) * 16'(avg_a_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_valid_reg <= 1'b0;
        else if (state_reg == bads_pkg::ST_PACK && dst_free)
            dst_valid_reg <= 1'b1;
        else if (dst_ready)
            dst_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bads_pkg::ST_PACK && dst_free)
        begin
            dst_reg.pixel565  <= {hi_c[7:3], col_g_reg[7:2], lo_c[7:3]};
            dst_reg.row_end   <= rend;
            dst_reg.image_end <= iend;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_pixel = dst_reg;

    // ---------------- datapath payload ----------------
    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
            pix_reg <= src_pixel;
        if (state_reg == bads_pkg::ST_READ)
        begin
            sum_r_reg <= new_r;
            sum_g_reg <= new_g;
            sum_b_reg <= new_b;
            sum_a_reg <= new_a;
            area_reg  <= (area_calc == '0) ? AREA_W'(1) : area_calc;
        end
        if (state_reg == bads_pkg::ST_WAIT && div_done)
        begin
            case (op_reg)
                bads_pkg::OP_COL:   col_next_reg <= div_q;
                bads_pkg::OP_ROW:   row_next_reg <= div_q;
                bads_pkg::OP_RED:   avg_r_reg    <= q_byte;
                bads_pkg::OP_GREEN: avg_g_reg    <= q_byte;
                bads_pkg::OP_BLUE:  avg_b_reg    <= q_byte;
                bads_pkg::OP_ALPHA: avg_a_reg    <= q_byte;
                default:            ;
            endcase
        end
        // alpha premultiply, color * alpha / 256
        if (state_reg == bads_pkg::ST_MUL)
        begin
            if (bpp_reg && premult_reg)
            begin
                col_r_reg <= prod_r[15:8];
                col_g_reg <= prod_g[15:8];
                col_b_reg <= prod_b[15:8];
            end
            else
            begin
                col_r_reg <= avg_r_reg;
                col_g_reg <= avg_g_reg;
                col_b_reg <= avg_b_reg;
            end
        end
    end

    // ---------------- control and position state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            op_reg        <= bads_pkg::OP_E1;
            init_reg      <= 1'b0;
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            col_edge_reg  <= '0;
            col_start_reg <= '0;
            row_edge_reg  <= '0;
            row_start_reg <= '0;
            e1_reg        <= '0;
            n_eff_reg     <= '0;
            d_eff_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                bads_pkg::ST_CFG:
                begin
                    n_eff_reg   <= n_calc;
                    d_eff_reg   <= d_calc;
                    init_reg    <= 1'b1;
                    pending_reg <= OP_COUNT_W'(1) << bads_pkg::OP_E1;
                end
                bads_pkg::ST_READ:
                begin
                    if (in_range && col_done)
                        pending_reg[bads_pkg::OP_COL] <= 1'b1;
                    if (emit || (row_last && band_last))
                        pending_reg[bads_pkg::OP_ROW] <= 1'b1;
                    if (emit)
                    begin
                        pending_reg[bads_pkg::OP_RED]   <= 1'b1;
                        pending_reg[bads_pkg::OP_GREEN] <= 1'b1;
                        pending_reg[bads_pkg::OP_BLUE]  <= 1'b1;
                        pending_reg[bads_pkg::OP_ALPHA] <= 1'b1;
                    end
                end
                bads_pkg::ST_OP:
                begin
                    if (op_any)
                    begin
                        op_reg               <= op_pick;
                        pending_reg[op_pick] <= 1'b0;
                    end
                    else
                        init_reg <= 1'b0;
                end
                bads_pkg::ST_WAIT:
                begin
                    // first edge known: restart the frame
                    if (div_done && op_reg == bads_pkg::OP_E1)
                    begin
                        e1_reg        <= div_q;
                        col_edge_reg  <= div_q;
                        row_edge_reg  <= div_q;
                        col_start_reg <= '0;
                        row_start_reg <= '0;
                        src_col_reg   <= '0;
                        src_row_reg   <= '0;
                        out_col_reg   <= '0;
                        out_row_reg   <= '0;
                    end
                end
                bads_pkg::ST_COMMIT:
                begin
                    if (row_last)
                    begin
                        src_col_reg   <= '0;
                        out_col_reg   <= '0;
                        col_start_reg <= '0;
                        col_edge_reg  <= e1_reg;
                        if (frame_last)
                        begin
                            src_row_reg   <= '0;
                            out_row_reg   <= '0;
                            row_start_reg <= '0;
                            row_edge_reg  <= e1_reg;
                        end
                        else
                        begin
                            src_row_reg <= src_row_reg + 1'b1;
                            if (band_last)
                            begin
                                out_row_reg   <= out_row_reg + 1'b1;
                                row_start_reg <= row_edge_reg;
                                row_edge_reg  <= row_next_reg;
                            end
                        end
                    end
                    else
                    begin
                        src_col_reg <= src_col_reg + 1'b1;
                        if (in_range && col_done)
                        begin
                            out_col_reg   <= out_col_reg + 1'b1;
                            col_start_reg <= col_edge_reg;
                            col_edge_reg  <= col_next_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/bads_chk.sv
// port-level checker for the box-average downscaler, bound to the top level
// depends on bads_pkg for the payload types and register index codes
`timescale 1ns / 1ps

module bads_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             src_valid,
    input logic                             src_ready,
    input logic                             dst_valid,
    input logic                             dst_ready,
    input bads_pkg::out_pix_t               dst_pixel,
    input logic                             cfg_write,
    input logic [bads_pkg::CFG_INDEX_W-1:0] cfg_index
);

    // a stalled result transaction holds its payload
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_pixel))
        else $error("dst transaction changed while stalled");

    // the last pixel of the image also ends its row
    a_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (!dst_pixel.image_end || dst_pixel.row_end))
        else $error("image_end without row_end");

    // one pixel at a time: busy right after a source transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> !src_ready)
        else $error("source taken on consecutive cycles");

    // a register write restarts the frame, which stalls the source
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index < bads_pkg::CFG_COUNT) |=> !src_ready)
        else $error("source ready right after a register write");

endmodule

bind box_average_downscale_rgb565 bads_chk u_bads_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_pixel (dst_pixel),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index)
);

// File: bench/tb_box_average_downscale_rgb565.sv
// self-checking bench for the box-average rgb565 downscaler
// depends on bads_pkg and box_average_downscale_rgb565; holds its own block-average predictor
`timescale 1ns / 1ps

// scoreboard: tracks the frame position and column sums, predicts the averaged pixels,
// and compares each delivered pixel with the oldest pending prediction
class downscale_scoreboard;
    bit [12:0] width_reg, height_reg, num_reg;
    bit [8:0]  den_reg;
    bit        bpp_reg, premult_reg, swap_reg;
    int unsigned acc_r[256], acc_g[256], acc_b[256], acc_a[256];
    int unsigned scol, srow, ocol, orow, cedge, redge;
    bads_pkg::out_pix_t pending[$];
    int errors;
    int produced;

    function new();
        width_reg = 128; height_reg = 160; num_reg = 1; den_reg = 1;
        bpp_reg = 0; premult_reg = 0; swap_reg = 0;
        foreach (acc_r[i])
        begin
            acc_r[i] = 0; acc_g[i] = 0; acc_b[i] = 0; acc_a[i] = 0;
        end
        errors = 0;
        produced = 0;
        restart();
    endfunction

    function int unsigned den_eff();
        return den_reg == 0 ? 1 : den_reg;
    endfunction

    function int unsigned num_eff();
        int unsigned d;
        int unsigned n;
        d = den_eff();
        n = num_reg;
        if (n < d) n = d;
        if (n > d * 32) n = d * 32;
        return n;
    endfunction

    function int unsigned dim_eff(int unsigned v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function int unsigned edge_of(int unsigned k);
        return (k * num_eff()) / den_eff();
    endfunction

    function void restart();
        scol = 0; srow = 0; ocol = 0; orow = 0;
        cedge = edge_of(1);
        redge = edge_of(1);
    endfunction

    function void write_reg(bit [2:0] idx, bit [12:0] val);
        case (idx)
            bads_pkg::CFG_SRC_WIDTH:  width_reg = val;
            bads_pkg::CFG_SRC_HEIGHT: height_reg = val;
            bads_pkg::CFG_SCALE_NUM:  num_reg = val;
            bads_pkg::CFG_SCALE_DEN:  den_reg = val[8:0];
            bads_pkg::CFG_BPP_MODE:   bpp_reg = val[0];
            bads_pkg::CFG_PREMULT:    premult_reg = val[0];
            bads_pkg::CFG_SWAP_RB:    swap_reg = val[0];
            default: return;
        endcase
        restart();
    endfunction

    function int unsigned avg_byte(int unsigned s, int unsigned area);
        int unsigned v;
        v = s / area;
        return v > 255 ? 255 : v;
    endfunction

    // note an accepted source pixel and queue the block average it completes, if any
    function void note_pixel(bads_pkg::in_pix_t p);
        int unsigned w, h, area, cr, cg, cb, ca, hi, lo;
        bit col_done;
        bads_pkg::out_pix_t o;
        w = dim_eff(width_reg);
        h = dim_eff(height_reg);
        col_done = (scol + 1 == cedge);
        if (ocol < 256)
        begin
            if (srow == edge_of(orow))
            begin
                acc_r[ocol] = p.red; acc_g[ocol] = p.green;
                acc_b[ocol] = p.blue; acc_a[ocol] = p.alpha;
            end
            else
            begin
                acc_r[ocol] += p.red; acc_g[ocol] += p.green;
                acc_b[ocol] += p.blue; acc_a[ocol] += p.alpha;
            end
            if (col_done && srow + 1 == redge)
            begin
                area = (cedge - edge_of(ocol)) * (redge - edge_of(orow));
                if (area == 0) area = 1;
                cr = avg_byte(acc_r[ocol], area);
                cg = avg_byte(acc_g[ocol], area);
                cb = avg_byte(acc_b[ocol], area);
                if (bpp_reg && premult_reg)
                begin
                    ca = avg_byte(acc_a[ocol], area);
                    cr = (cr * ca) >> 8;
                    cg = (cg * ca) >> 8;
                    cb = (cb * ca) >> 8;
                end
                hi = swap_reg ? cb : cr;
                lo = swap_reg ? cr : cb;
                o.pixel565 = {hi[7:3], cg[7:2], lo[7:3]};
                o.row_end = (ocol + 1 >= 256) || (edge_of(ocol + 2) > w);
                o.image_end = o.row_end && (edge_of(orow + 2) > h);
                pending.push_back(o);
            end
            if (col_done)
            begin
                ocol++;
                cedge = edge_of(ocol + 1);
            end
        end
        if (scol + 1 >= w)
        begin
            scol = 0;
            ocol = 0;
            cedge = edge_of(1);
            if (srow + 1 == redge)
            begin
                orow++;
                redge = edge_of(orow + 1);
            end
            srow++;
            if (srow >= h) restart();
        end
        else
            scol++;
    endfunction

    function void check_result(bads_pkg::out_pix_t got);
        bads_pkg::out_pix_t exp_pix;
        produced++;
        if (pending.size() == 0)
        begin
            $error("unexpected output pixel %h", got);
            errors++;
            return;
        end
        exp_pix = pending.pop_front();
        if (got.pixel565 !== exp_pix.pixel565)
        begin
            $error("pixel565 expected %h actual %h", exp_pix.pixel565, got.pixel565);
            errors++;
        end
        if (got.row_end !== exp_pix.row_end)
        begin
            $error("row_end expected %b actual %b", exp_pix.row_end, got.row_end);
            errors++;
        end
        if (got.image_end !== exp_pix.image_end)
        begin
            $error("image_end expected %b actual %b", exp_pix.image_end, got.image_end);
            errors++;
        end
    endfunction
endclass

module tb_box_average_downscale_rgb565;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 src_valid;
    logic                 src_ready;
    bads_pkg::in_pix_t    src_pixel;
    logic                 dst_valid;
    logic                 dst_ready;
    bads_pkg::out_pix_t   dst_pixel;
    logic                 cfg_write;
    logic [bads_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bads_pkg::CFG_DATA_W-1:0]  cfg_data;

    downscale_scoreboard board;

    // idle percentages for each side, changed between phases
    int src_idle_pct;
    int dst_stall_pct;
    bit hold_dst;          // long receiver hold-off
    int idle_cycles;       // cycles with no transaction, for the watchdog
    int sent_pixels;

    box_average_downscale_rgb565 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_pixel (src_pixel),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_pixel (dst_pixel),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: ready toggles at the falling edge, transactions checked at the rising edge
    always @(negedge clk)
    begin
        if (!rst_n || hold_dst)
            dst_ready <= 1'b0;
        else
            dst_ready <= ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && dst_ready)
            board.check_result(dst_pixel);
    end

    // watchdog: counts cycles with no transaction on either channel and no register write
    always @(posedge clk)
    begin
        if ((src_valid && src_ready) || (dst_valid && dst_ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d pending", board.pending.size());
            $display("tb_box_average_downscale_rgb565: errors");
            $finish;
        end
    end

    // offer one pixel and hold it until the transaction completes;
    // valid drops only when the sender idles or stops
    task automatic send_pixel(input bads_pkg::in_pix_t p);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_pixel <= p;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        board.note_pixel(p);
        sent_pixels++;
        @(negedge clk);
    endtask

    task automatic send_random(input int n);
        repeat (n)
            send_pixel(bads_pkg::in_pix_t'($urandom));
        src_valid <= 1'b0;
    endtask

    // wait for every predicted pixel, then let a trailing divide finish
    task automatic drain();
        src_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bads_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[bads_pkg::CFG_DATA_W-1:0];
        board.write_reg(idx, val[bads_pkg::CFG_DATA_W-1:0]);
        @(negedge clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned n, input int unsigned d,
                             input bit bpp, input bit pm, input bit sw);
        drain();
        write_reg(bads_pkg::CFG_SRC_WIDTH, w);
        write_reg(bads_pkg::CFG_SRC_HEIGHT, h);
        write_reg(bads_pkg::CFG_SCALE_NUM, n);
        write_reg(bads_pkg::CFG_SCALE_DEN, d);
        write_reg(bads_pkg::CFG_BPP_MODE, bpp);
        write_reg(bads_pkg::CFG_PREMULT, pm);
        write_reg(bads_pkg::CFG_SWAP_RB, sw);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_pixel = '0;
        dst_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_dst = 1'b0;
        idle_cycles = 0;
        sent_pixels = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: 1:1 blocks, extreme channel values, swap on and off
        set_frame(4, 2, 1, 1, 0, 0, 0);
        send_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
        send_pixel('{8'hff, 8'hff, 8'hff, 8'hff});
        send_pixel('{8'h00, 8'hff, 8'h00, 8'hff});
        send_pixel('{8'hff, 8'h00, 8'hff, 8'h00});
        set_frame(3, 1, 1, 1, 0, 0, 1);
        send_pixel('{8'h12, 8'hff, 8'h80, 8'h01});
        send_pixel('{8'h00, 8'h08, 8'hff, 8'hf7});
        send_pixel('{8'hff, 8'hff, 8'hff, 8'hff});
        // premultiply with opaque and half alpha; 2x2 blocks
        set_frame(4, 2, 2, 1, 1, 1, 0);
        send_pixel('{8'hff, 8'hff, 8'hff, 8'hff});
        send_pixel('{8'hff, 8'hff, 8'hff, 8'hff});
        send_pixel('{8'h80, 8'hc0, 8'h40, 8'hff});
        send_pixel('{8'h80, 8'hc0, 8'h40, 8'h00});
        send_random(4);
        // fractional ratio 3:2 with a trailing partial column; zero size and ratio registers
        set_frame(5, 4, 3, 2, 1, 0, 1);
        send_random(20);
        set_frame(0, 0, 0, 0, 0, 0, 0);
        send_random(3);
        // ratio below one, ratio above the block limit
        set_frame(3, 2, 1, 4, 0, 0, 0);
        send_random(6);
        set_frame(40, 33, 4095, 1, 1, 1, 1);
        send_random(40 * 2);

        // random phases: each idling profile, random geometry
        for (int ph = 0; ph < 8; ph++)
        begin
            int unsigned w, h, d;
            case (ph % 4)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 87; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 87; end
                default: begin src_idle_pct = 35; dst_stall_pct = 35; end
            endcase
            d = $urandom_range(1, 4);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_frame(w, h, $urandom_range(d, 3 * d), d, 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
            send_random(15);
        end

        // wide output row past the column store limit, with 1:1 scale
        src_idle_pct = 0;
        dst_stall_pct = 0;
        set_frame(258, 1, 1, 1, 0, 0, 0);
        send_random(258);

        // long receiver hold-off while the sender keeps offering pixels
        set_frame(4, 4, 1, 1, 1, 1, 0);
        hold_dst = 1'b1;
        fork
            send_random(30);
            begin
                repeat (3000) @(negedge clk);
                hold_dst = 1'b0;
            end
        join
        // sender pauses until every prediction has been delivered
        drain();
        send_random(16);

        drain();
        $display("covered %0d source pixels, %0d output pixels, ratios 1:1 to 3:1,",
                 sent_pixels, board.produced);
        $display("block clamp, premultiply, swap, partial edges, store overflow, back-pressure");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_box_average_downscale_rgb565: clean");
        else
            $display("tb_box_average_downscale_rgb565: errors");
        $finish;
    end
endmodule
